// ----- sv/skst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skst_pkg
// Shared types and constants for the sorted key set table: the request
// actions, the result status codes, the sequencer states and the result record.
// ----------------------------------------------------------------------------
package skst_pkg;

   // Table size and the widths that follow from it.
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths.
   localparam int ACT_W = 3;
   localparam int KEY_W = 17;
   localparam int GRP_W = 7;
   localparam int ST_W  = 3;

   // Operand ranges and the group span.
   localparam logic [KEY_W-1:0] KEY_MIN    = KEY_W'(10000);
   localparam logic [KEY_W-1:0] KEY_MAX    = KEY_W'(99999);
   localparam logic [GRP_W-1:0] GROUP_MIN  = GRP_W'(10);
   localparam logic [GRP_W-1:0] GROUP_MAX  = GRP_W'(99);
   localparam logic [KEY_W-1:0] GROUP_SPAN = KEY_W'(1000);

   // Request actions.
   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT     = 3'd0,
      ACT_DELETE     = 3'd1,
      ACT_SEARCH     = 3'd2,
      ACT_LIST_GROUP = 3'd3,
      ACT_LIST_ALL   = 3'd4
   } action_type;

   // Result status codes.
   typedef enum logic [ST_W-1:0] {
      STAT_OK     = 3'd0,
      STAT_DUP    = 3'd1,
      STAT_ABSENT = 3'd2,
      STAT_FULL   = 3'd3,
      STAT_BAD    = 3'd4
   } status_type;

   // Request sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // One result record.
   typedef struct packed {
      status_type       status;
      logic             found;
      logic             entry_valid;
      logic [KEY_W-1:0] entry_key;
      logic [CNT_W-1:0] entry_count;
      logic             last;
   } rsp_type;

endpackage

// ----- sv/skst_rsp_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skst_rsp_reg
// Result output register. Holds one result record until the consumer takes
// it and tells the sequencer when a new record can be loaded.
// ----------------------------------------------------------------------------
module skst_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  skst_pkg::rsp_type load_data,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output skst_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   skst_pkg::rsp_type data_ff;
   skst_pkg::rsp_type data_in;

   // The register can take a record when empty or when its record leaves now.
   assign free = !valid_ff || !rsp_stall;

   // Next value of the register.
   always_comb begin
      valid_in = load || (valid_ff && rsp_stall);
      data_in  = load ? load_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- sv/sorted_key_set_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_set_table
// Ascending set of distinct five-digit codes held in one synchronous memory,
// with insert, delete, search and listing requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  action, key, group
//  rsp_      out        rsp_valid/rsp_stall  status, found, entry_valid,
//                                            entry_key, entry_count, last
//
//  A request posts its closing result after its scan: one memory read per
//  stored entry through the single read port, then work on the last read
//  data, then the step out of the scan, then the posting of the result.
//  The next request can transfer in the cycle after the result is posted.
//  A request with a bad operand skips the scan, posts its result directly
//  and reads nothing.
//  Reset is synchronous and empties the table at once; no clearing pass.
//  A stalled result channel pauses a listing scan at the next match and holds
//  the closing result; req_stall stays high while a request is in service.
// ----------------------------------------------------------------------------
module sorted_key_set_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [skst_pkg::ACT_W-1:0]  req_action,
   input  logic [skst_pkg::KEY_W-1:0]  req_key,
   input  logic [skst_pkg::GRP_W-1:0]  req_group,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [skst_pkg::ST_W-1:0]   rsp_status,
   output logic                        rsp_found,
   output logic                        rsp_entry_valid,
   output logic [skst_pkg::KEY_W-1:0]  rsp_entry_key,
   output logic [skst_pkg::CNT_W-1:0]  rsp_entry_count,
   output logic                        rsp_last
);

   // Sequencer and request registers.
   skst_pkg::state_type               state_ff, state_in;
   logic [skst_pkg::ACT_W-1:0]        act_ff, act_in;
   logic [skst_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [skst_pkg::KEY_W-1:0]        lo_ff, lo_in;
   logic [skst_pkg::KEY_W-1:0]        hi_ff, hi_in;
   logic                              bad_ff, bad_in;
   logic                              full_ff, full_in;
   logic                              hit_ff, hit_in;
   logic [skst_pkg::CNT_W-1:0]        occ_ff, occ_in;
   logic [skst_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic [skst_pkg::IDX_W-1:0]        cur_ff, cur_in;
   logic                              rdv_ff, rdv_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [skst_pkg::KEY_W-1:0]        pend_key_ff, pend_key_in;

   // Entry memory and its ports.
   logic [skst_pkg::KEY_W-1:0]        entry_mem [skst_pkg::CAPACITY];
   logic [skst_pkg::KEY_W-1:0]        rd_data_ff;
   logic                              rd_en;
   logic [skst_pkg::IDX_W-1:0]        rd_addr;
   logic                              wr_en;
   logic [skst_pkg::IDX_W-1:0]        wr_addr;
   logic [skst_pkg::KEY_W-1:0]        wr_data;

   // Result register interface.
   logic                              rsp_load;
   skst_pkg::rsp_type                 rsp_next;
   skst_pkg::rsp_type                 rsp_data;
   logic                              out_free;

   // Decode and scan helpers.
   logic                              accept;
   logic                              bad_op;
   logic                              key_bad;
   logic                              is_list;
   logic                              list_hit;
   logic                              blocked;
   logic [skst_pkg::KEY_W-1:0]        grp_lo;

   assign accept  = req_valid && !req_stall;
   assign req_stall = (state_ff != skst_pkg::S_IDLE);

   // Operand checks on the incoming request.
   assign key_bad = (req_key < skst_pkg::KEY_MIN) || (req_key > skst_pkg::KEY_MAX);
   assign grp_lo  = skst_pkg::KEY_W'(req_group) * skst_pkg::GROUP_SPAN;

   always_comb begin
      unique case (req_action) inside
         skst_pkg::ACT_INSERT, skst_pkg::ACT_DELETE, skst_pkg::ACT_SEARCH: begin
            bad_op = key_bad;
         end
         skst_pkg::ACT_LIST_GROUP: begin
            bad_op = (req_group < skst_pkg::GROUP_MIN) || (req_group > skst_pkg::GROUP_MAX);
         end
         skst_pkg::ACT_LIST_ALL: begin
            bad_op = 1'b0;
         end
         default: begin
            bad_op = 1'b1;
         end
      endcase
   end

   // A listing matches an entry inside the group's key window, or any entry.
   assign is_list  = (act_ff == skst_pkg::ACT_LIST_GROUP) || (act_ff == skst_pkg::ACT_LIST_ALL);
   assign list_hit = (act_ff == skst_pkg::ACT_LIST_ALL) ||
                     ((rd_data_ff >= lo_ff) && (rd_data_ff < hi_ff));

   // The scan halts on a match that must push out the held entry while the
   // result register is still occupied.
   assign blocked = rdv_ff && is_list && list_hit && pend_valid_ff && !out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skst_pkg::S_IDLE: begin
            if (accept) begin
               state_in = bad_op ? skst_pkg::S_DONE : skst_pkg::S_SCAN;
            end
         end
         skst_pkg::S_SCAN: begin
            if (!rdv_ff && (idx_ff == occ_ff)) begin
               state_in = skst_pkg::S_DONE;
            end
         end
         skst_pkg::S_DONE: begin
            if (out_free) begin
               state_in = skst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = skst_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath, memory ports and result loading.
   always_comb begin
      act_in        = act_ff;
      key_in        = key_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      bad_in        = bad_ff;
      full_in       = full_ff;
      hit_in        = hit_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      rdv_in        = rdv_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[skst_pkg::IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = key_ff;
      rsp_load      = 1'b0;
      rsp_next      = '0;

      unique case (state_ff)
         skst_pkg::S_IDLE: begin
            // Capture the request and start the scan at entry zero.
            if (accept) begin
               act_in        = req_action;
               key_in        = req_key;
               lo_in         = grp_lo;
               hi_in         = grp_lo + skst_pkg::GROUP_SPAN;
               bad_in        = bad_op;
               full_in       = (occ_ff == skst_pkg::CNT_W'(skst_pkg::CAPACITY));
               hit_in        = 1'b0;
               idx_in        = '0;
               rdv_in        = 1'b0;
               pend_valid_in = 1'b0;
            end
         end

         skst_pkg::S_SCAN: begin
            if (!blocked) begin
               // Work on the entry that the last read returned.
               if (rdv_ff) begin
                  case (act_ff)
                     skst_pkg::ACT_INSERT: begin
                        // Ripple the carried key upward: a larger entry takes
                        // its place and moves on. A duplicate always shows up
                        // before any write, and a full table is never written.
                        if (!hit_ff) begin
                           if (rd_data_ff == key_ff) begin
                              hit_in = 1'b1;
                           end else if ((rd_data_ff > key_ff) && !full_ff) begin
                              wr_en   = 1'b1;
                              wr_addr = cur_ff;
                              wr_data = key_ff;
                              key_in  = rd_data_ff;
                           end
                        end
                     end
                     skst_pkg::ACT_DELETE: begin
                        // After the match, every entry moves down one place.
                        if (hit_ff) begin
                           wr_en   = 1'b1;
                           wr_addr = cur_ff - skst_pkg::IDX_W'(1);
                           wr_data = rd_data_ff;
                        end else if (rd_data_ff == key_ff) begin
                           hit_in = 1'b1;
                        end
                     end
                     skst_pkg::ACT_SEARCH: begin
                        if (rd_data_ff == key_ff) begin
                           hit_in = 1'b1;
                        end
                     end
                     default: begin
                        // Listing: hold one match back so the final one can
                        // carry the last flag.
                        if (list_hit) begin
                           if (pend_valid_ff) begin
                              rsp_load             = 1'b1;
                              rsp_next.status      = skst_pkg::STAT_OK;
                              rsp_next.entry_valid = 1'b1;
                              rsp_next.entry_key   = pend_key_ff;
                              rsp_next.entry_count = occ_ff;
                              rsp_next.last        = 1'b0;
                           end
                           pend_valid_in = 1'b1;
                           pend_key_in   = rd_data_ff;
                        end
                     end
                  endcase
               end

               // Issue the next read while stored entries remain.
               if (idx_ff < occ_ff) begin
                  rd_en  = 1'b1;
                  rd_addr = idx_ff[skst_pkg::IDX_W-1:0];
                  cur_in = idx_ff[skst_pkg::IDX_W-1:0];
                  idx_in = idx_ff + skst_pkg::CNT_W'(1);
                  rdv_in = 1'b1;
               end else begin
                  rdv_in = 1'b0;
               end
            end
         end

         skst_pkg::S_DONE: begin
            // Post the closing result and commit the occupancy change.
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_next.status = skst_pkg::STAT_OK;
               rsp_next.last   = 1'b1;
               if (bad_ff) begin
                  rsp_next.status = skst_pkg::STAT_BAD;
               end else begin
                  case (act_ff) inside
                     skst_pkg::ACT_INSERT: begin
                        if (hit_ff) begin
                           rsp_next.status = skst_pkg::STAT_DUP;
                        end else if (full_ff) begin
                           rsp_next.status = skst_pkg::STAT_FULL;
                        end else begin
                           // The carried key lands in the new top slot.
                           wr_en   = 1'b1;
                           wr_addr = occ_ff[skst_pkg::IDX_W-1:0];
                           wr_data = key_ff;
                           occ_in  = occ_ff + skst_pkg::CNT_W'(1);
                        end
                     end
                     skst_pkg::ACT_DELETE: begin
                        if (hit_ff) begin
                           occ_in = occ_ff - skst_pkg::CNT_W'(1);
                        end else begin
                           rsp_next.status = skst_pkg::STAT_ABSENT;
                        end
                     end
                     skst_pkg::ACT_SEARCH: begin
                        rsp_next.found = hit_ff;
                     end
                     skst_pkg::ACT_LIST_GROUP, skst_pkg::ACT_LIST_ALL: begin
                        if (pend_valid_ff) begin
                           rsp_next.entry_valid = 1'b1;
                           rsp_next.entry_key   = pend_key_ff;
                        end
                     end
                     default: begin
                        rsp_next.status = skst_pkg::STAT_BAD;
                     end
                  endcase
               end
               rsp_next.entry_count = occ_in;
            end
         end

         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Entry memory: one write and one registered read per cycle. The scan
   // never reads an address that is written in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= skst_pkg::S_IDLE;
         occ_ff        <= '0;
         rdv_ff        <= 1'b0;
         hit_ff        <= 1'b0;
         bad_ff        <= 1'b0;
         full_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         rdv_ff        <= rdv_in;
         hit_ff        <= hit_in;
         bad_ff        <= bad_in;
         full_ff       <= full_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      pend_key_ff <= pend_key_in;
   end

   // Result output register.
   skst_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_next),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_status      = rsp_data.status;
   assign rsp_found       = rsp_data.found;
   assign rsp_entry_valid = rsp_data.entry_valid;
   assign rsp_entry_key   = rsp_data.entry_key;
   assign rsp_entry_count = rsp_data.entry_count;
   assign rsp_last        = rsp_data.last;

endmodule

// ----- sv/skst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skst_checker
// Port-level checks on the result channel of the sorted key set table,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module skst_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [skst_pkg::ST_W-1:0]   rsp_status,
   input logic                        rsp_found,
   input logic                        rsp_entry_valid,
   input logic [skst_pkg::KEY_W-1:0]  rsp_entry_key,
   input logic [skst_pkg::CNT_W-1:0]  rsp_entry_count,
   input logic                        rsp_last
);

   // A stalled result stays offered, its status, key, count and last flag unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_entry_key) && $stable(rsp_entry_count) && $stable(rsp_last)))
      else $error("stalled result changed");

   // The reported count never exceeds the table size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= skst_pkg::CNT_W'(skst_pkg::CAPACITY)))
      else $error("entry count above capacity");

   // A result without a listed entry carries a zero key.
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_valid) |-> (rsp_entry_key == '0))
      else $error("key present without a listed entry");

   // Any failing status closes its request and lists nothing.
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != skst_pkg::STAT_OK)) |-> (rsp_last && !rsp_entry_valid &&
         !rsp_found))
      else $error("failing status on a listing or non-final result");

   // A search hit is a single successful closing result.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_last && !rsp_entry_valid &&
         (rsp_status == skst_pkg::STAT_OK)))
      else $error("found flag on a non-search result");

endmodule

bind sorted_key_set_table skst_checker u_skst_checker (.*);

// ----- tb/sorted_key_set_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_set_table_tb
// Self-checking bench for the sorted key set table. A driver process feeds
// requests from a backlog that is filled at time zero. Each accepted request
// is run through a behavioral copy of the ascending key set, which queues
// the answers it should produce. A monitor process compares every result
// transfer, field by field, against the oldest queued answer. Both sides
// idle in random bursts. The receiver holds off once for a long stretch
// while the table is full, and the sender waits for the table to go quiet
// at a few points.
// ----------------------------------------------------------------------------
module sorted_key_set_table_tb;

   // Reserved action codes that the block must reject.
   localparam logic [skst_pkg::ACT_W-1:0] ACT_RESERVED_FIRST = 3'd5;
   localparam logic [skst_pkg::ACT_W-1:0] ACT_RESERVED_LAST  = 3'd7;

   localparam int MAX_REPORTS      = 10;
   localparam int TAIL_ITEMS       = 40;
   localparam int PHASE_CYCLES     = 64;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 200;
   localparam int MIXED_EARLY      = 100;
   localparam int MIXED_LATE       = 60;
   localparam int FILL_ITEMS       = 80;
   localparam int DRAIN_ITEMS      = 70;

   typedef struct {
      logic [skst_pkg::ACT_W-1:0] action;
      logic [skst_pkg::KEY_W-1:0] key;
      logic [skst_pkg::GRP_W-1:0] grp;
      bit                         pause_here;
   } request_item_type;

   logic                          clock;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic [skst_pkg::ACT_W-1:0]    req_action      = '0;
   logic [skst_pkg::KEY_W-1:0]    req_key         = '0;
   logic [skst_pkg::GRP_W-1:0]    req_group       = '0;
   logic                          rsp_valid;
   logic                          rsp_stall       = 1'b0;
   logic [skst_pkg::ST_W-1:0]     rsp_status;
   logic                          rsp_found;
   logic                          rsp_entry_valid;
   logic [skst_pkg::KEY_W-1:0]    rsp_entry_key;
   logic [skst_pkg::CNT_W-1:0]    rsp_entry_count;
   logic                          rsp_last;

   // Stimulus backlog, the mirrored key set and the answers still owed.
   request_item_type              request_backlog[$];
   logic [skst_pkg::KEY_W-1:0]    stored_keys[$];
   skst_pkg::rsp_type             owed_answers[$];
   logic [skst_pkg::KEY_W-1:0]    key_pool[$];
   int                            hot_groups[5] = '{10, 11, 45, 98, 99};

   int                            error_count     = 0;
   bit                            calm_tail       = 1'b0;
   request_item_type              next_request;
   skst_pkg::rsp_type             oldest_answer;

   // Driver-side and receiver-side pacing state.
   int                            send_gap_left;
   int                            send_phase_left;
   int                            send_idle_pct;
   int                            stall_left;
   int                            recv_phase_left;
   int                            recv_idle_pct;
   int                            hold_left;
   bit                            hold_done;

   sorted_key_set_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_group       (req_group),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_entry_key   (rsp_entry_key),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Applies one accepted request to the mirrored key set and queues the
   // answers that it must produce.
   task automatic apply_request(input logic [skst_pkg::ACT_W-1:0] act,
                                input logic [skst_pkg::KEY_W-1:0] k,
                                input logic [skst_pkg::GRP_W-1:0] g);
      skst_pkg::rsp_type ans;
      skst_pkg::rsp_type listing[$];
      int                pos;
      int                slot;
      bit                key_ok;
      pos    = -1;
      key_ok = (k >= skst_pkg::KEY_MIN) && (k <= skst_pkg::KEY_MAX);
      foreach (stored_keys[i])
         if (stored_keys[i] == k)
            pos = i;
      ans.status      = skst_pkg::STAT_OK;
      ans.found       = 1'b0;
      ans.entry_valid = 1'b0;
      ans.entry_key   = '0;
      ans.last        = 1'b1;

      if (act <= skst_pkg::ACT_SEARCH && !key_ok) begin
         ans.status = skst_pkg::STAT_BAD;
      end else begin
         case (act)
            skst_pkg::ACT_INSERT: begin
               if (pos >= 0) begin
                  ans.status = skst_pkg::STAT_DUP;
               end else if (stored_keys.size() >= skst_pkg::CAPACITY) begin
                  ans.status = skst_pkg::STAT_FULL;
               end else begin
                  // Keep the set ascending.
                  slot = stored_keys.size();
                  foreach (stored_keys[i])
                     if (stored_keys[i] > k && i < slot)
                        slot = i;
                  stored_keys.insert(slot, k);
               end
            end
            skst_pkg::ACT_DELETE: begin
               if (pos < 0)
                  ans.status = skst_pkg::STAT_ABSENT;
               else
                  stored_keys.delete(pos);
            end
            skst_pkg::ACT_SEARCH: begin
               ans.found = (pos >= 0);
            end
            skst_pkg::ACT_LIST_GROUP, skst_pkg::ACT_LIST_ALL: begin
               if (act == skst_pkg::ACT_LIST_GROUP &&
                   (g < skst_pkg::GROUP_MIN || g > skst_pkg::GROUP_MAX)) begin
                  ans.status = skst_pkg::STAT_BAD;
               end else begin
                  foreach (stored_keys[i]) begin
                     if (act == skst_pkg::ACT_LIST_ALL ||
                         stored_keys[i] / skst_pkg::GROUP_SPAN == g) begin
                        ans.entry_valid = 1'b1;
                        ans.entry_key   = stored_keys[i];
                        ans.last        = 1'b0;
                        ans.entry_count = skst_pkg::CNT_W'(stored_keys.size());
                        listing.push_back(ans);
                     end
                  end
               end
            end
            default: begin
               ans.status = skst_pkg::STAT_BAD;
            end
         endcase
      end

      // A listing with matches ends on its final entry; anything else
      // gives one result.
      if (listing.size() > 0) begin
         listing[listing.size() - 1].last = 1'b1;
         foreach (listing[i])
            owed_answers.push_back(listing[i]);
      end else begin
         ans.entry_count = skst_pkg::CNT_W'(stored_keys.size());
         owed_answers.push_back(ans);
      end
   endtask

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 45;
      endcase
   endfunction

   // Draws a key: often one used before, else half the time in a few busy groups,
   // sometimes any 17-bit value and otherwise any in-range key.
   function automatic logic [skst_pkg::KEY_W-1:0] pick_key(input int reuse_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (key_pool.size() > 0 && roll < reuse_pct)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return skst_pkg::KEY_W'($urandom_range(0, (1 << skst_pkg::KEY_W) - 1));
      if (roll < 60)
         return skst_pkg::KEY_W'(hot_groups[$urandom_range(0, 4)] * skst_pkg::GROUP_SPAN
                                 + $urandom_range(0, 999));
      return skst_pkg::KEY_W'($urandom_range(skst_pkg::KEY_MIN, skst_pkg::KEY_MAX));
   endfunction

   function automatic logic [skst_pkg::GRP_W-1:0] pick_group();
      if ($urandom_range(0, 3) != 0)
         return skst_pkg::GRP_W'(hot_groups[$urandom_range(0, 4)]);
      return skst_pkg::GRP_W'($urandom_range(0, (1 << skst_pkg::GRP_W) - 1));
   endfunction

   task automatic queue_request(input logic [skst_pkg::ACT_W-1:0] act,
                                input logic [skst_pkg::KEY_W-1:0] k,
                                input logic [skst_pkg::GRP_W-1:0] g);
      request_item_type item;
      item.action     = act;
      item.key        = k;
      item.grp        = g;
      item.pause_here = 1'b0;
      request_backlog.push_back(item);
   endtask

   // Marks a point where the sender waits until every answer has arrived.
   task automatic queue_pause();
      request_item_type item;
      item.action     = skst_pkg::ACT_SEARCH;
      item.key        = '0;
      item.grp        = '0;
      item.pause_here = 1'b1;
      request_backlog.push_back(item);
   endtask

   task automatic queue_random_request();
      int                         roll;
      logic [skst_pkg::KEY_W-1:0] k;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         k = pick_key(20);
         key_pool.push_back(k);
         queue_request(skst_pkg::ACT_INSERT, k, pick_group());
      end else if (roll < 55) begin
         queue_request(skst_pkg::ACT_DELETE, pick_key(75), pick_group());
      end else if (roll < 70) begin
         queue_request(skst_pkg::ACT_SEARCH, pick_key(50), pick_group());
      end else if (roll < 82) begin
         queue_request(skst_pkg::ACT_LIST_GROUP, pick_key(0), pick_group());
      end else if (roll < 90) begin
         queue_request(skst_pkg::ACT_LIST_ALL, pick_key(0), pick_group());
      end else begin
         queue_request(skst_pkg::ACT_W'($urandom_range(ACT_RESERVED_FIRST,
                                                       ACT_RESERVED_LAST)),
                       pick_key(30), pick_group());
      end
   endtask

   // Stimulus, reset and the end of the run.
   initial begin
      logic [skst_pkg::KEY_W-1:0] k;

      // Directed part: empty table, range edges, duplicates, every action.
      queue_request(skst_pkg::ACT_LIST_ALL, '0, '0);
      queue_request(skst_pkg::ACT_LIST_GROUP, '0, skst_pkg::GROUP_MIN);
      queue_request(skst_pkg::ACT_SEARCH, skst_pkg::KEY_MIN, '0);
      queue_request(skst_pkg::ACT_DELETE, skst_pkg::KEY_MIN, '0);
      queue_request(skst_pkg::ACT_INSERT, skst_pkg::KEY_MAX, '0);
      queue_request(skst_pkg::ACT_INSERT, skst_pkg::KEY_W'(50500), '0);
      queue_request(skst_pkg::ACT_INSERT, skst_pkg::KEY_MIN, '0);
      queue_request(skst_pkg::ACT_INSERT, skst_pkg::KEY_W'(50001), '0);
      queue_request(skst_pkg::ACT_INSERT, skst_pkg::KEY_W'(50500), '0);
      queue_request(skst_pkg::ACT_INSERT, skst_pkg::KEY_MIN - skst_pkg::KEY_W'(1), '0);
      queue_request(skst_pkg::ACT_DELETE, skst_pkg::KEY_MAX + skst_pkg::KEY_W'(1), '0);
      queue_request(skst_pkg::ACT_SEARCH, '0, '0);
      queue_request(skst_pkg::ACT_INSERT, '1, '1);
      queue_request(skst_pkg::ACT_SEARCH, skst_pkg::KEY_W'(50500), '0);
      queue_request(skst_pkg::ACT_LIST_GROUP, '0, skst_pkg::GRP_W'(50));
      queue_request(skst_pkg::ACT_LIST_GROUP, '0, skst_pkg::GROUP_MIN);
      queue_request(skst_pkg::ACT_LIST_GROUP, '0, skst_pkg::GROUP_MAX);
      queue_request(skst_pkg::ACT_LIST_GROUP, '0, skst_pkg::GRP_W'(11));
      queue_request(skst_pkg::ACT_LIST_GROUP, '0,
                    skst_pkg::GROUP_MIN - skst_pkg::GRP_W'(1));
      queue_request(skst_pkg::ACT_LIST_GROUP, '0,
                    skst_pkg::GROUP_MAX + skst_pkg::GRP_W'(1));
      queue_request(skst_pkg::ACT_LIST_GROUP, '1, '1);
      queue_request(skst_pkg::ACT_LIST_ALL, '0, '0);
      queue_request(skst_pkg::ACT_DELETE, skst_pkg::KEY_W'(50001), '0);
      for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++)
         queue_request(skst_pkg::ACT_W'(a), skst_pkg::KEY_W'(50500), skst_pkg::GROUP_MAX);
      queue_request(skst_pkg::ACT_SEARCH, skst_pkg::KEY_W'(50001), '0);
      queue_pause();

      // Mixed traffic around a few busy groups.
      repeat (MIXED_EARLY)
         queue_random_request();
      queue_pause();

      // Fill the table past capacity with distinct keys, then read it back.
      for (int i = 0; i < FILL_ITEMS; i++) begin
         k = skst_pkg::KEY_W'(70000 + i * 97 + $urandom_range(0, 96));
         key_pool.push_back(k);
         queue_request(skst_pkg::ACT_INSERT, k, pick_group());
      end
      queue_request(skst_pkg::ACT_LIST_ALL, '0, '0);
      queue_request(skst_pkg::ACT_LIST_GROUP, '0, skst_pkg::GRP_W'(70));
      queue_request(skst_pkg::ACT_LIST_GROUP, '0, skst_pkg::GRP_W'(77));
      queue_request(skst_pkg::ACT_LIST_GROUP, '0, pick_group());
      queue_request(skst_pkg::ACT_SEARCH, pick_key(100), '0);
      queue_request(skst_pkg::ACT_INSERT, pick_key(0), '0);
      queue_pause();

      // Drain most of it again.
      for (int i = 0; i < DRAIN_ITEMS; i++) begin
         if ($urandom_range(0, 4) != 0)
            queue_request(skst_pkg::ACT_DELETE, pick_key(90), pick_group());
         else
            queue_request(skst_pkg::ACT_SEARCH, pick_key(50), pick_group());
         if (i == DRAIN_ITEMS / 2)
            queue_request(skst_pkg::ACT_LIST_ALL, '0, '0);
      end

      repeat (MIXED_LATE)
         queue_random_request();
      queue_request(skst_pkg::ACT_LIST_ALL, '0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every answer to arrive.
      while (request_backlog.size() != 0 || req_valid || owed_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Request driver: holds a stalled request, otherwise idles or presents
   // the next one from the backlog.
   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_action      <= '0;
         req_key         <= '0;
         req_group       <= '0;
         calm_tail       <= 1'b0;
         send_gap_left   = 0;
         send_phase_left = 0;
         send_idle_pct   = 0;
      end else begin
         // A request transfer completes at this edge.
         if (req_valid && !req_stall)
            apply_request(req_action, req_key, req_group);

         // Change the idle rate now and then.
         if (send_phase_left == 0) begin
            send_phase_left = PHASE_CYCLES;
            send_idle_pct   = pick_idle_pct();
         end else begin
            send_phase_left--;
         end
         calm_tail <= (request_backlog.size() <= TAIL_ITEMS);

         if (req_valid && req_stall) begin
            // Payload stays put until the transfer.
         end else if (send_gap_left > 0) begin
            send_gap_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (request_backlog[0].pause_here) begin
            req_valid <= 1'b0;
            if (!req_valid && owed_answers.size() == 0)
               void'(request_backlog.pop_front());
         end else if (!calm_tail && $urandom_range(0, 99) < send_idle_pct) begin
            send_gap_left = $urandom_range(0, 4);
            req_valid <= 1'b0;
         end else begin
            next_request = request_backlog.pop_front();
            req_valid  <= 1'b1;
            req_action <= next_request.action;
            req_key    <= next_request.key;
            req_group  <= next_request.grp;
         end
      end
   end

   // Result receiver: random stall bursts, plus one long hold-off on the
   // first result that reports a full table.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall       <= 1'b0;
         stall_left      = 0;
         recv_phase_left = 0;
         recv_idle_pct   = 0;
         hold_left       = 0;
         hold_done       = 1'b0;
      end else begin
         if (recv_phase_left == 0) begin
            recv_phase_left = PHASE_CYCLES;
            recv_idle_pct   = pick_idle_pct();
         end else begin
            recv_phase_left--;
         end

         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_valid && rsp_entry_count == skst_pkg::CAPACITY) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm_tail && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result monitor: every result transfer must match the oldest owed answer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_answers.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display({"ERROR: unexpected result: status %0d found %0b valid %0b",
                         " key %0d count %0d last %0b"},
                        rsp_status, rsp_found, rsp_entry_valid, rsp_entry_key,
                        rsp_entry_count, rsp_last);
         end else begin
            oldest_answer = owed_answers.pop_front();
            if (rsp_status !== oldest_answer.status ||
                rsp_found !== oldest_answer.found ||
                rsp_entry_valid !== oldest_answer.entry_valid ||
                rsp_entry_key !== oldest_answer.entry_key ||
                rsp_entry_count !== oldest_answer.entry_count ||
                rsp_last !== oldest_answer.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("ERROR: result mismatch at %0t", $realtime);
                  $display("  expected status %0d found %0b valid %0b key %0d count %0d last %0b",
                           oldest_answer.status, oldest_answer.found,
                           oldest_answer.entry_valid, oldest_answer.entry_key,
                           oldest_answer.entry_count, oldest_answer.last);
                  $display("  actual   status %0d found %0b valid %0b key %0d count %0d last %0b",
                           rsp_status, rsp_found, rsp_entry_valid, rsp_entry_key,
                           rsp_entry_count, rsp_last);
               end
            end
         end
      end
   end

endmodule

// ----- filelist.f -----
sv/skst_pkg.sv
sv/skst_rsp_reg.sv
sv/sorted_key_set_table.sv
sv/skst_checker.sv
tb/sorted_key_set_table_tb.sv
